/* design/assert_macros.svh */
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define AST_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/wrpt_pkg.sv */
// shared types and constants of the weighted random pick table
`default_nettype none

package wrpt_pkg;

    // default sizes
    localparam int GROUPS_DEF  = 16;
    localparam int ENTRIES_DEF = 32;

    // field widths
    localparam int CMD_W    = 2;
    localparam int GROUP_W  = 4;
    localparam int ID_W     = 16;
    localparam int WEIGHT_W = 20;
    localparam int RAND_W   = 20;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_GROUP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd3;

    // command beat
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [GROUP_W-1:0]  group;
        logic [ID_W-1:0]     entry_id;
        logic [WEIGHT_W-1:0] weight;
        logic [RAND_W-1:0]   random_value;
    } t_wrpt_in;

    // result beat
    typedef struct packed {
        logic [ID_W-1:0]     picked_id;
        logic [STATUS_W-1:0] status;
    } t_wrpt_out;

endpackage

`default_nettype wire

/* design/weighted_random_pick_table_top.sv */
// top level of the weighted random pick table: group counts, entry memory, draw walk
// clear, append, unused-code and rejected commands give their result in the cycle after accept
// a draw reads entry 0 with the accept, then walks the entries in S_RUN until a hit or the last entry
// a draw holds busy high while it walks, one memory read per entry, and takes no new beat meanwhile
// for other commands busy stays low and a new beat can start every cycle
// reset clears all group counts and the control state; the entry memory is not cleared
// results are one-cycle strobes on o_done; the receiver cannot stall
`default_nettype none

module weighted_random_pick_table_top
    import wrpt_pkg::*;
#(
    parameter int GROUPS  = GROUPS_DEF,
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_wrpt_in  i_item,
    output logic           busy,
    output logic           o_done,
    output t_wrpt_out      o_result
);

    // only groups reachable through the group field need storage
    localparam int NG    = (GROUPS < (1 << GROUP_W)) ? GROUPS : (1 << GROUP_W);
    localparam int GW    = $clog2(NG);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int DEPTH = NG * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = WEIGHT_W + CW;
    localparam int MW    = ID_W + WEIGHT_W;

    // state codes
    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    // control state
    logic                r_state, n_state;
    logic [CW-1:0]       r_cnt [NG];
    logic [CW-1:0]       n_cnt [NG];
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_n, n_n;
    logic [GW-1:0]       r_g, n_g;
    logic [RAND_W-1:0]   r_rand, n_rand;
    logic [SW-1:0]       r_sum, n_sum;
    logic                r_done, n_done;
    t_wrpt_out           r_res, n_res;

    // entry memory: id in the upper bits, weight in the lower
    logic [MW-1:0]       r_mem [DEPTH];
    logic [MW-1:0]       r_rdata;
    logic                mem_we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [GW-1:0]       addr_grp;
    logic [CW-1:0]       addr_off;

    // decode of the incoming beat
    logic                accept;
    logic                grp_ok;
    logic [GW-1:0]       grp_idx;
    logic [CW-1:0]       grp_cnt;
    logic [SW-1:0]       sum_add;
    logic [ID_W-1:0]     rd_id;
    logic [WEIGHT_W-1:0] rd_weight;

    assign accept    = start && (r_state == S_IDLE);
    assign grp_ok    = (i_item.group != '0) && (32'(i_item.group) < 32'(GROUPS));
    assign grp_idx   = i_item.group[GW-1:0];
    assign grp_cnt   = r_cnt[grp_idx];
    assign rd_id     = r_rdata[MW-1:WEIGHT_W];
    assign rd_weight = r_rdata[WEIGHT_W-1:0];
    assign sum_add   = r_sum + SW'(rd_weight);
    assign wr_addr   = AW'(32'(grp_idx) * ENTRIES + 32'(grp_cnt));
    assign rd_addr   = AW'(32'(addr_grp) * ENTRIES + 32'(addr_off));

    // command handling and draw walk
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_n      = r_n;
        n_g      = r_g;
        n_rand   = r_rand;
        n_sum    = r_sum;
        n_done   = 1'b0;
        n_res    = '0;
        mem_we   = 1'b0;
        addr_grp = grp_idx;
        addr_off = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.cmd)
                        CMD_CLEAR: begin
                            for (int i = 0; i < NG; i++) begin
                                n_cnt[i] = '0;
                            end
                            n_done = 1'b1;
                        end
                        CMD_APPEND: begin
                            n_done = 1'b1;
                            if (!grp_ok) begin
                                n_res.status = ST_BAD_GROUP;
                            end else if (i_item.weight != '0) begin
                                if (32'(grp_cnt) >= 32'(ENTRIES)) begin
                                    n_res.status = ST_FULL;
                                end else begin
                                    mem_we         = 1'b1;
                                    n_cnt[grp_idx] = grp_cnt + CW'(1);
                                end
                            end
                        end
                        CMD_DRAW: begin
                            if (!grp_ok) begin
                                n_done       = 1'b1;
                                n_res.status = ST_BAD_GROUP;
                            end else if (grp_cnt == '0) begin
                                n_done       = 1'b1;
                                n_res.status = ST_NO_MATCH;
                            end else begin
                                // first entry read goes out with the accept
                                n_state = S_RUN;
                                n_k     = '0;
                                n_n     = grp_cnt;
                                n_g     = grp_idx;
                                n_rand  = i_item.random_value;
                                n_sum   = '0;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN: begin
                // entry r_k is in the read register; fetch the next one meanwhile
                addr_grp = r_g;
                addr_off = r_k + CW'(1);
                n_sum    = sum_add;
                n_k      = r_k + CW'(1);
                if (sum_add > SW'(r_rand)) begin
                    n_done          = 1'b1;
                    n_res.picked_id = rd_id;
                    n_res.status    = ST_OK;
                    n_state         = S_IDLE;
                end else if (r_k + CW'(1) == r_n) begin
                    n_done       = 1'b1;
                    n_res.status = ST_NO_MATCH;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            for (int i = 0; i < NG; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // walk and result payload
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_n    <= n_n;
        r_g    <= n_g;
        r_rand <= n_rand;
        r_sum  <= n_sum;
        r_res  <= n_res;
    end

    // entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= {i_item.entry_id, i_item.weight};
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign busy     = (r_state == S_RUN);
    assign o_done   = r_done;
    assign o_result = r_res;

    // checks
`include "assert_macros.svh"

    `AST_NEXT(a_accept_progress, accept, o_done || busy, "accepted beat neither answered nor walking")
    `AST_HOLDS(a_walk_in_range, (r_state != S_RUN) || ((r_k < r_n) && (r_n != '0)), "draw walk index out of range")
    `AST_HOLDS(a_fail_zero_id, !o_done || (o_result.status == ST_OK) || (o_result.picked_id == '0), "failed result carries an id")
    `AST_NEXT(a_clear_empties, accept && (i_item.cmd == CMD_CLEAR), r_cnt[0] == '0 && r_cnt[NG-1] == '0, "clear left a group count")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// testbench of the weighted random pick table: directed and random beats against a predictor
`timescale 1ns / 1ps

module testbench;
    import wrpt_pkg::*;

    // command code that the block leaves without effect
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = ENTRIES_DEF + 4;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      o_done;
    t_wrpt_in  i_item;
    t_wrpt_out o_result;

    // predictor state: entries held per group and the stored pairs
    int unsigned       fill_count[GROUPS_DEF];
    logic [ID_W-1:0]   slot_id[GROUPS_DEF][ENTRIES_DEF];
    logic [WEIGHT_W-1:0] slot_weight[GROUPS_DEF][ENTRIES_DEF];

    t_wrpt_out pending_results[$];
    int        mismatches;
    int        beats_sent;
    bit        idle_on;

    weighted_random_pick_table_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // expected result of one beat; updates the predictor state
    function automatic t_wrpt_out predict_pick(input t_wrpt_in b);
        t_wrpt_out   res;
        logic [31:0] run_sum;
        bit          found;
        int          g;
        res = '0;
        res.status = ST_OK;
        g = int'(b.group);
        case (b.cmd)
            CMD_CLEAR: begin
                foreach (fill_count[i]) fill_count[i] = 0;
            end
            CMD_APPEND: begin
                if (g < 1 || g >= GROUPS_DEF) begin
                    res.status = ST_BAD_GROUP;
                end else if (b.weight != '0) begin
                    if (fill_count[g] >= ENTRIES_DEF) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_id[g][fill_count[g]]     = b.entry_id;
                        slot_weight[g][fill_count[g]] = b.weight;
                        fill_count[g]++;
                    end
                end
            end
            CMD_DRAW: begin
                if (g < 1 || g >= GROUPS_DEF) begin
                    res.status = ST_BAD_GROUP;
                end else begin
                    // walk the entries in append order, first running total above the value wins
                    res.status = ST_NO_MATCH;
                    run_sum = '0;
                    found = 1'b0;
                    for (int k = 0; k < int'(fill_count[g]); k++) begin
                        if (!found) begin
                            run_sum = run_sum + 32'(slot_weight[g][k]);
                            if (run_sum > 32'(b.random_value)) begin
                                res.picked_id = slot_id[g][k];
                                res.status = ST_OK;
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_wrpt_in make_beat(input logic [CMD_W-1:0] cmd,
                                           input int grp, input int eid,
                                           input int wgt, input int rv);
        t_wrpt_in b;
        b.cmd          = cmd;
        b.group        = GROUP_W'(grp);
        b.entry_id     = ID_W'(eid);
        b.weight       = WEIGHT_W'(wgt);
        b.random_value = RAND_W'(rv);
        return b;
    endfunction

    // random filler for fields a command does not use
    function automatic t_wrpt_in noisy_beat(input logic [CMD_W-1:0] cmd, input int grp);
        return make_beat(cmd, grp, $urandom_range(0, 65535), $urandom_range(0, 1048575),
                         $urandom_range(0, 1048575));
    endfunction

    // sender gap: mostly short, a few long, none while idling is off
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one beat and hold it until the block takes it
    task automatic issue_beat(input t_wrpt_in b);
        int        gap;
        t_wrpt_out want;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        want = predict_pick(b);
        pending_results = {pending_results, want};
        beats_sent++;
    endtask

    // result checker: each strobed beat against the oldest expectation
    always @(posedge i_clk) begin
        t_wrpt_out want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual id %h status %0d",
                         $time, o_result.picked_id, o_result.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.picked_id !== want.picked_id) begin
                    $display("%0t: picked_id expected %h actual %h",
                             $time, want.picked_id, o_result.picked_id);
                    mismatches++;
                end
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    mismatches++;
                end
            end
        end
    end

    // clear, unused code, group zero, zero-weight append and empty-group draws
    task automatic test_commands_and_bad_groups();
        issue_beat(noisy_beat(CMD_CLEAR, 0));
        issue_beat(make_beat(CMD_UNUSED, 15, 65535, 1048575, 1048575));
        issue_beat(make_beat(CMD_APPEND, 0, 4660, 500, 0));
        issue_beat(make_beat(CMD_DRAW, 0, 0, 0, 0));
        issue_beat(make_beat(CMD_DRAW, 5, 0, 0, 0));
        // zero weight is skipped, so the group stays empty
        issue_beat(make_beat(CMD_APPEND, 5, 43981, 0, 0));
        issue_beat(make_beat(CMD_DRAW, 5, 0, 0, 0));
    endtask

    // field extremes and the strict running-total boundary
    task automatic test_draw_extremes();
        issue_beat(make_beat(CMD_APPEND, 1, 65535, 1, 0));
        issue_beat(make_beat(CMD_APPEND, 1, 0, 1048575, 0));
        issue_beat(make_beat(CMD_APPEND, 1, 42405, 1000000, 0));
        issue_beat(make_beat(CMD_DRAW, 1, 0, 0, 0));
        issue_beat(make_beat(CMD_DRAW, 1, 0, 0, 1048575));
        issue_beat(make_beat(CMD_APPEND, 15, 4660, 300000, 0));
        issue_beat(make_beat(CMD_APPEND, 15, 22136, 700000, 0));
        issue_beat(make_beat(CMD_DRAW, 15, 0, 0, 299999));
        issue_beat(make_beat(CMD_DRAW, 15, 0, 0, 300000));
        issue_beat(make_beat(CMD_DRAW, 15, 0, 0, 999999));
        issue_beat(make_beat(CMD_DRAW, 15, 0, 0, 1000000));
        issue_beat(make_beat(CMD_DRAW, 15, 0, 0, 1048575));
    endtask

    // random traffic: clears, unused codes, group-zero beats, appends, overflow fills, draws
    task automatic test_random_traffic(input int beat_goal);
        int          pick;
        int          g;
        int          wgt;
        int          rv;
        int          extra;
        logic [31:0] total;
        beat_goal = beat_goal + beats_sent;
        while (beats_sent < beat_goal) begin
            idle_on = ($urandom_range(0, 99) >= 20);
            pick = $urandom_range(0, 99);
            g = $urandom_range(1, GROUPS_DEF - 1);
            if (pick < 2) begin
                issue_beat(noisy_beat(CMD_CLEAR, $urandom_range(0, 15)));
            end else if (pick < 5) begin
                issue_beat(noisy_beat(CMD_UNUSED, $urandom_range(0, 15)));
            end else if (pick < 9) begin
                issue_beat(noisy_beat($urandom_range(0, 1) ? CMD_APPEND : CMD_DRAW, 0));
            end else if (pick < 13) begin
                // fill one group past its capacity, then draw from it
                while (fill_count[g] < ENTRIES_DEF)
                    issue_beat(make_beat(CMD_APPEND, g, $urandom_range(0, 65535),
                                         $urandom_range(1, 60000), $urandom_range(0, 1048575)));
                extra = $urandom_range(1, 3);
                repeat (extra)
                    issue_beat(make_beat(CMD_APPEND, g, $urandom_range(0, 65535),
                                         $urandom_range(1, 1048575), $urandom_range(0, 1048575)));
                repeat (3)
                    issue_beat(make_beat(CMD_DRAW, g, $urandom_range(0, 65535),
                                         $urandom_range(0, 1048575), $urandom_range(0, 1048575)));
            end else if (pick < 55) begin
                case ($urandom_range(0, 9))
                    0:       wgt = 0;
                    1:       wgt = $urandom_range(0, 1048575);
                    2:       wgt = $urandom_range(0, 1) ? 1000000 : 1048575;
                    default: wgt = $urandom_range(1, 150000);
                endcase
                issue_beat(make_beat(CMD_APPEND, g, $urandom_range(0, 65535), wgt,
                                     $urandom_range(0, 1048575)));
            end else begin
                total = '0;
                for (int k = 0; k < int'(fill_count[g]); k++)
                    total = total + 32'(slot_weight[g][k]);
                if (total > 32'd1048575) total = 32'd1048575;
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: rv = $urandom_range(0, 999999);
                    4, 5, 6:    rv = $urandom_range(0, 1048575);
                    7, 8:       rv = int'(total);
                    9:          rv = (total == 0) ? 0 : int'(total) - 1;
                    default:    rv = (total == 0) ? 0 : $urandom_range(0, int'(total) - 1);
                endcase
                issue_beat(make_beat(CMD_DRAW, g, $urandom_range(0, 65535),
                                     $urandom_range(0, 1048575), rv));
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        mismatches = 0;
        beats_sent = 0;
        idle_on = 1'b1;
        foreach (fill_count[i]) fill_count[i] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_commands_and_bad_groups();
        test_draw_extremes();
        test_random_traffic(1000);

        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(4_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
